@@ rtl/dmhq_pkg.sv @@
// dmhq_pkg: shared types and constants for the min priority queue
// no dependencies; imported by the interfaces, the cell and the top level
package dmhq_pkg;

    localparam int KEY_W        = 32;
    localparam int DEF_CAPACITY = 64;
    localparam int OCC_W        = 7;
    localparam logic [KEY_W-1:0] KEY_ONES = '1;

    // request opcode
    typedef enum logic [0:0] {
        MODE_INSERT  = 1'b0,
        MODE_EXTRACT = 1'b1
    } mode_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_EXTRACTED = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // operation broadcast along the cell row
    typedef enum logic [1:0] {
        CELL_HOLD    = 2'd0,
        CELL_INSERT  = 2'd1,
        CELL_EXTRACT = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [KEY_W-1:0] key;
    } cell_cmd_t;

endpackage

@@ rtl/dmhq_in_if.sv @@
// dmhq_in_if: request channel (valid/ready, opcode and key)
// depends on dmhq_pkg
interface dmhq_in_if
    import dmhq_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [0:0]       mode;
    logic [KEY_W-1:0] key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

@@ rtl/dmhq_out_if.sv @@
// dmhq_out_if: result channel (valid/ready, key, status, occupancy)
// depends on dmhq_pkg
interface dmhq_out_if
    import dmhq_pkg::*;
#(
    parameter int OCC_BITS = OCC_W
)();
    logic                valid;
    logic                ready;
    logic [KEY_W-1:0]    out_key;
    logic [1:0]          status;
    logic [OCC_BITS-1:0] occupancy;

    modport source (output valid, output out_key, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input out_key, input status, input occupancy,
                    output ready);
endinterface

@@ rtl/dmhq_cell.sv @@
// dmhq_cell: one slot of the sorted key row
// depends on dmhq_pkg; instantiated in a chain by d_ary_min_heap_queue
module dmhq_cell
    import dmhq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_cmd_t        cmd,
    input  logic [KEY_W-1:0] left_key,
    input  logic             left_keep,
    input  logic [KEY_W-1:0] right_key,
    output logic [KEY_W-1:0] key,
    output logic             keep
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;

    // slot stays put on insert when its key is not above the new one
    assign keep = (key_reg <= cmd.key);
    assign key  = key_reg;

    // insert shifts right from the insertion point, extract shifts left
    always_comb
    begin
        key_next = key_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (!keep)
                begin
                    key_next = left_keep ? cmd.key : left_key;
                end
            end
            CELL_EXTRACT:
            begin
                key_next = right_key;
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    // empty slots hold all-ones
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= KEY_ONES;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

endmodule

@@ rtl/d_ary_min_heap_queue.sv @@
// d_ary_min_heap_queue: top level of the min priority queue
// depends on dmhq_pkg, dmhq_in_if, dmhq_out_if and dmhq_cell
//
// Min priority queue of 32-bit unsigned keys, kept as a row of CAPACITY
// cells sorted ascending, the minimum in cell 0 and free cells at all-ones.
// Each transaction is an insert or an extract-min: an
// insert is broadcast to every cell, which compares it with its own key and
// either holds, takes the new key or takes its left neighbor's key; an
// extract returns cell 0 and every cell takes its right neighbor's key. One
// result follows each transaction from a result register, so a new request
// is taken whenever that register is empty or being read, for a sustained
// rate of one transaction per clock. Inserting into a full queue or
// extracting from an empty one leaves the contents alone and reports
// status 2 or 3 with a zero key. Occupancy is the key count after the
// operation. No clearing pass is needed after reset.
module d_ary_min_heap_queue
    import dmhq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)(
    input  logic        clk,
    input  logic        rst_n,
    dmhq_in_if.sink     req,
    dmhq_out_if.source  res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             res_valid_reg;
    logic [KEY_W-1:0] res_key_reg;
    logic [1:0]       res_status_reg;
    logic [CNT_W-1:0] res_occ_reg;
    logic [KEY_W-1:0] res_key_next;
    status_t          res_status_next;

    logic             accept;
    cell_cmd_t        cmd;
    logic [KEY_W-1:0] cell_key  [CAPACITY];
    logic             cell_keep [CAPACITY];

    // request taken when the result slot is free or draining
    assign req.ready = !res_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;

    // decode the transaction into a row command and its result
    always_comb
    begin
        cmd.op          = CELL_HOLD;
        cmd.key         = req.key;
        count_next      = count_reg;
        res_key_next    = '0;
        res_status_next = ST_INSERTED;
        case (mode_t'(req.mode))
            MODE_INSERT:
            begin
                if (count_reg >= CAP_CNT)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    cmd.op          = accept ? CELL_INSERT : CELL_HOLD;
                    count_next      = count_reg + 1'b1;
                    res_status_next = ST_INSERTED;
                end
            end
            MODE_EXTRACT:
            begin
                if (count_reg == '0)
                begin
                    res_status_next = ST_EMPTY;
                end
                else
                begin
                    cmd.op          = accept ? CELL_EXTRACT : CELL_HOLD;
                    count_next      = count_reg - 1'b1;
                    res_key_next    = cell_key[0];
                    res_status_next = ST_EXTRACTED;
                end
            end
            default:
            begin
                res_status_next = ST_INSERTED;
            end
        endcase
    end

    // row of cells, each linked to both neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_W-1:0] left_key;
        logic             left_keep;
        logic [KEY_W-1:0] right_key;

        if (i == 0)
        begin : g_first
            assign left_key  = cmd.key;
            assign left_keep = 1'b1;
        end
        else
        begin : g_mid
            assign left_key  = cell_key[i-1];
            assign left_keep = cell_keep[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_key = KEY_ONES;
        end
        else
        begin : g_inner
            assign right_key = cell_key[i+1];
        end

        dmhq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .left_key  (left_key),
            .left_keep (left_keep),
            .right_key (right_key),
            .key       (cell_key[i]),
            .keep      (cell_keep[i])
        );
    end

    // key count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_key_reg    <= res_key_next;
            res_status_reg <= res_status_next;
            res_occ_reg    <= count_next;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.out_key   = res_key_reg;
    assign res.status    = res_status_reg;
    assign res.occupancy = res_occ_reg;

endmodule
